[rtl/cmni_pkg.sv]
package cmni_pkg;

  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 24;
  localparam int OUT_BITS  = 32;
  localparam int LANES     = 9;

  // row sum, cofactor product, cofactor, determinant and numerator widths
  localparam int SW   = COEF_BITS + 2;
  localparam int PW   = 2 * COEF_BITS;
  localparam int CFW  = PW + 1;
  localparam int DPW  = COEF_BITS + CFW;
  localparam int DW   = DPW + 2;
  localparam int NUMW = CFW + SW;
  localparam int NSW  = NUMW + FRAC_BITS;
  // rounded dividend 2|n|+|d| and divisor 2|d|
  localparam int NW   = NSW + 2;
  localparam int DDW  = DW + 1;
  localparam int XW   = ((NW > DDW + OUT_BITS) ? NW : DDW + OUT_BITS) + 1;

  localparam int FRONT_LAT = 4;
  localparam int LANE_LAT  = 3 + OUT_BITS;
  localparam int LAT       = FRONT_LAT + LANE_LAT + 1;

  localparam int IN_BITS  = LANES * COEF_BITS;
  localparam int IN_BYTES = (IN_BITS + 7) / 8;
  localparam int OD_BITS  = LANES * OUT_BITS;
  localparam int OD_BYTES = (OD_BITS + 7) / 8;

  localparam logic [OUT_BITS-1:0] SAT_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] SAT_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ROW_ZERO  = 2'd1,
    ST_SINGULAR  = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [NUMW-1:0]      num_t;
  typedef logic signed [DW-1:0]        det_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] val;
    logic                sat;
  } lane_res_t;

endpackage

[rtl/cmni_front.sv]
module cmni_front (
  input  logic                clk_i,
  input  logic                en_i,
  input  cmni_pkg::coef_t     a_i [9],
  output cmni_pkg::num_t      num_o [9],
  output cmni_pkg::det_t      det_o,
  output logic                row_zero_o
);

  // stage 1: row 0 coefficients, row sums, cofactor products
  cmni_pkg::coef_t                      a1_q [3];
  logic signed [cmni_pkg::SW-1:0]       s1_q [3];
  logic signed [cmni_pkg::PW-1:0]       p0_q [9];
  logic signed [cmni_pkg::PW-1:0]       p1_q [9];
  // stage 2: cofactors
  logic signed [cmni_pkg::CFW-1:0]      cof_q [9];
  logic signed [cmni_pkg::SW-1:0]       s2_q [3];
  cmni_pkg::coef_t                      a2_q [3];
  logic                                 rz2_q;
  // stage 3: determinant terms and numerators
  logic signed [cmni_pkg::DPW-1:0]      dp_q [3];
  cmni_pkg::num_t                       np_q [9];
  logic                                 rz3_q;
  // stage 4
  cmni_pkg::num_t                       num_q [9];
  cmni_pkg::det_t                       det_q;
  logic                                 rz4_q;

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a1_q[r] <= a_i[r];
        s1_q[r] <= cmni_pkg::SW'(a_i[r*3]) + cmni_pkg::SW'(a_i[r*3+1])
                 + cmni_pkg::SW'(a_i[r*3+2]);
        s2_q[r] <= s1_q[r];
        a2_q[r] <= a1_q[r];
        dp_q[r] <= a2_q[r] * cof_q[r];
      end
    end
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p0_q[r*3+c]  <= a_i[((r+1)%3)*3 + (c+1)%3] * a_i[((r+2)%3)*3 + (c+2)%3];
          p1_q[r*3+c]  <= a_i[((r+1)%3)*3 + (c+2)%3] * a_i[((r+2)%3)*3 + (c+1)%3];
          cof_q[r*3+c] <= cmni_pkg::CFW'(p0_q[r*3+c]) - cmni_pkg::CFW'(p1_q[r*3+c]);
          // entry (r,c) of the inverse uses cofactor (c,r) and row sum c
          np_q[r*3+c]  <= cof_q[c*3+r] * s2_q[c];
          num_q[r*3+c] <= np_q[r*3+c];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rz2_q <= (s1_q[0] == '0) | (s1_q[1] == '0) | (s1_q[2] == '0);
      rz3_q <= rz2_q;
      rz4_q <= rz3_q;
      det_q <= cmni_pkg::DW'(dp_q[0]) + cmni_pkg::DW'(dp_q[1]) + cmni_pkg::DW'(dp_q[2]);
    end
  end

  assign num_o      = num_q;
  assign det_o      = det_q;
  assign row_zero_o = rz4_q;

endmodule

[rtl/cmni_lane.sv]
module cmni_lane (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  cmni_pkg::num_t       num_i,
  input  cmni_pkg::det_t       det_i,
  output cmni_pkg::lane_res_t  res_o
);

  localparam int QB = cmni_pkg::OUT_BITS;

  logic signed [cmni_pkg::NSW-1:0] nsh;
  logic [cmni_pkg::NSW-1:0]        nm1_q;
  logic [cmni_pkg::DW-1:0]         dm1_q;
  logic                            neg1_q;
  logic [cmni_pkg::NW-1:0]         n2_q;
  logic [cmni_pkg::DDW-1:0]        d2_q;
  logic                            neg2_q;
  logic [cmni_pkg::XW-1:0]         thr;

  // long division, one quotient bit per stage
  logic [cmni_pkg::XW-1:0]  r_q   [QB];
  logic [cmni_pkg::DDW-1:0] d_q   [QB];
  logic [QB-1:0]            q_q   [QB+1];
  logic                     neg_q [QB+1];
  logic                     ovf_q [QB+1];

  assign nsh = {num_i, {cmni_pkg::FRAC_BITS{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= num_i[cmni_pkg::NUMW-1] ^ det_i[cmni_pkg::DW-1];
      nm1_q  <= nsh[cmni_pkg::NSW-1] ? cmni_pkg::NSW'(-nsh) : cmni_pkg::NSW'(nsh);
      dm1_q  <= det_i[cmni_pkg::DW-1] ? cmni_pkg::DW'(-det_i) : cmni_pkg::DW'(det_i);
      // round half away: floor((2n + d) / 2d)
      n2_q   <= cmni_pkg::NW'({nm1_q, 1'b0}) + cmni_pkg::NW'(dm1_q);
      d2_q   <= {dm1_q, 1'b0};
      neg2_q <= neg1_q;
    end
  end

  // quotient exceeds the limit when n >= d * (limit + 1)
  assign thr = (cmni_pkg::XW'(d2_q) << (QB - 1))
             + (neg2_q ? cmni_pkg::XW'(d2_q) : cmni_pkg::XW'(0));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= cmni_pkg::XW'(n2_q);
      d_q[0]   <= d2_q;
      q_q[0]   <= '0;
      neg_q[0] <= neg2_q;
      ovf_q[0] <= cmni_pkg::XW'(n2_q) >= thr;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [cmni_pkg::XW-1:0] dsh;
    logic                    geq;
    assign dsh = cmni_pkg::XW'(d_q[i]) << (QB - 1 - i);
    assign geq = r_q[i] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i+1]   <= {q_q[i][QB-2:0], geq};
        neg_q[i+1] <= neg_q[i];
        ovf_q[i+1] <= ovf_q[i];
      end
    end
    if (i < QB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[i+1] <= geq ? r_q[i] - dsh : r_q[i];
          d_q[i+1] <= d_q[i];
        end
      end
    end
  end

  always_comb begin
    res_o.sat = ovf_q[QB];
    if (ovf_q[QB]) begin
      res_o.val = neg_q[QB] ? cmni_pkg::SAT_NEG : cmni_pkg::SAT_POS;
    end else begin
      res_o.val = neg_q[QB] ? QB'(-q_q[QB]) : q_q[QB];
    end
  end

endmodule

[rtl/color_matrix_normalize_invert_top.sv]
// throughput: one matrix per cycle; the front end, the nine divider lanes and
//   the output register all advance together, stalling only on m_axis_tready
// reset: rst_ni async active low clears the valid pipeline; data regs are not reset
module color_matrix_normalize_invert_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (16b signed each)
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cmni_pkg::IN_BYTES*8-1:0]     s_axis_tdata,
  // tdata: out_r0c0 .. out_r2c2 (32b signed q8.24 each)
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cmni_pkg::OD_BYTES*8-1:0]     m_axis_tdata,
  // tuser: status
  output logic [1:0]                          m_axis_tuser
);

  localparam int OB = cmni_pkg::OUT_BITS;

  logic                  en;
  logic [cmni_pkg::LAT-1:0] v_q;

  cmni_pkg::coef_t       a [9];
  cmni_pkg::num_t        num [9];
  cmni_pkg::det_t        det;
  logic                  row_zero;
  cmni_pkg::lane_res_t   res [9];
  cmni_pkg::status_e     pre_st;
  cmni_pkg::status_e     st_q [cmni_pkg::LANE_LAT];

  logic [cmni_pkg::OD_BYTES*8-1:0] odata_d, odata_q;
  cmni_pkg::status_e               ost_d, ost_q;
  logic                            any_sat;

  // whole pipeline moves when the output register is empty or being drained
  assign en            = ~v_q[cmni_pkg::LAT-1] | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[cmni_pkg::LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[cmni_pkg::LAT-2:0], s_axis_tvalid};
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_unpack
    assign a[i] = s_axis_tdata[i*cmni_pkg::COEF_BITS +: cmni_pkg::COEF_BITS];
  end

  // sums, cofactors, determinant and numerators
  cmni_front u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .a_i        (a),
    .num_o      (num),
    .det_o      (det),
    .row_zero_o (row_zero)
  );

  // one rounding divider per inverse entry
  for (genvar i = 0; i < 9; i++) begin : g_lane
    cmni_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[i]),
      .det_i (det),
      .res_o (res[i])
    );
  end

  // zero row sum wins over a singular matrix
  always_comb begin
    if (row_zero) begin
      pre_st = cmni_pkg::ST_ROW_ZERO;
    end else if (det == '0) begin
      pre_st = cmni_pkg::ST_SINGULAR;
    end else begin
      pre_st = cmni_pkg::ST_OK;
    end
  end

  // status delay line matching the lane depth
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= pre_st;
      for (int i = 1; i < cmni_pkg::LANE_LAT; i++) begin
        st_q[i] <= st_q[i-1];
      end
    end
  end

  // merge: collect lane results and saturation flags; a row-zero or singular status clears the data
  always_comb begin
    odata_d = '0;
    any_sat = 1'b0;
    for (int i = 0; i < 9; i++) begin
      odata_d[i*OB +: OB] = res[i].val;
      any_sat             = any_sat | res[i].sat;
    end
    if (st_q[cmni_pkg::LANE_LAT-1] != cmni_pkg::ST_OK) begin
      odata_d = '0;
      ost_d   = st_q[cmni_pkg::LANE_LAT-1];
    end else if (any_sat) begin
      ost_d   = cmni_pkg::ST_SATURATED;
    end else begin
      ost_d   = cmni_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      odata_q <= odata_d;
      ost_q   <= ost_d;
    end
  end

  assign m_axis_tdata = odata_q;
  assign m_axis_tuser = ost_q;

endmodule
